// ----- src/assert_macros.svh -----
// assertion macros used by the checker
// no dependencies

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset given as active-low enable
`define CHK_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/btgc_pkg.sv -----
// shared widths, defaults and register codes for the box-to-grid-cells block
// no dependencies

package btgc_pkg;

	localparam int TAG_W   = 16;
	localparam int COORD_W = 16;
	localparam int EXT_W   = 15;
	localparam int SIZE_W  = 13;
	localparam int DIM_W   = 9;
	localparam int CFG_W   = 13;
	localparam int CFG_AW  = 2;
	localparam int IDX_W   = 16;
	localparam int LANES   = 4;

	localparam int MAX_CELLS_DEF = 64;
	localparam int MAX_GRID_DEF  = 256;

	localparam logic [SIZE_W-1:0] CELL_SIZE_RST = 13'd32;
	localparam logic [DIM_W-1:0]  DIM_RST       = 9'd32;

	// corner lanes: left, right, top, bottom
	localparam int LANE_X0 = 0;
	localparam int LANE_X1 = 1;
	localparam int LANE_Y0 = 2;
	localparam int LANE_Y1 = 3;

	typedef enum logic [CFG_AW-1:0] {
		REG_CELL_SIZE    = 2'd0,
		REG_GRID_COLUMNS = 2'd1,
		REG_GRID_ROWS    = 2'd2
	} cfg_reg_t;

endpackage

// ----- src/box_to_grid_cells_unit.sv -----
// Box-to-grid-cells unit. Takes one box item (tag, left, top, width, height), maps both
// corners to clamped grid cells and returns one result item per covered cell, row by row
// and left to right, marking the last and flagging truncation past MAX_CELLS. The front
// end is a pipeline: a corner stage, a clamp stage, a restoring divider retiring two
// quotient bits per stage, and a range stage. The output enumerator produces one cell per
// cycle while cell_ready is high, so boxes covering a single cell also flow at one per cycle
// while cell_ready is high. Configuration writes are registered, and the clamp limits are
// registered once more from the configuration registers.
// Depends on btgc_pkg.

module box_to_grid_cells_unit
	import btgc_pkg::*;
#(
	parameter int MAX_CELLS = MAX_CELLS_DEF,
	parameter int MAX_GRID  = MAX_GRID_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_AW-1:0]         cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      box_valid,
	output logic                      box_ready,
	input  logic [TAG_W-1:0]          object_tag,
	input  logic signed [COORD_W-1:0] box_left,
	input  logic signed [COORD_W-1:0] box_top,
	input  logic [EXT_W-1:0]          box_width,
	input  logic [EXT_W-1:0]          box_height,
	output logic                      cell_valid,
	input  logic                      cell_ready,
	output logic [TAG_W-1:0]          tag_out,
	output logic [IDX_W-1:0]          cell_index,
	output logic                      last_cell,
	output logic                      truncated
);

	localparam int GW  = $clog2(MAX_GRID + 1);
	localparam int QW  = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
	localparam int LW  = GW + SIZE_W;
	localparam int CMW = (LW > COORD_W) ? LW : COORD_W;
	localparam int DW  = SIZE_W + QW;
	localparam int RW  = (DW > COORD_W) ? DW : COORD_W;
	localparam int SPS = 2;
	localparam int NDS = (QW + SPS - 1) / SPS;
	localparam int NW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int PW  = QW + GW;

	typedef struct packed {
		logic [TAG_W-1:0]                 tag;
		logic [LANES-1:0]                 hi;
		logic [LANES-1:0][COORD_W-1:0]    rem;
		logic [LANES-1:0][QW-1:0]         quo;
	} dv_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [QW-1:0]    x0;
		logic [QW-1:0]    x1;
		logic [QW-1:0]    y0;
		logic [QW-1:0]    y1;
		logic [IDX_W-1:0] rowst;
	} rng_t;

	function automatic logic [GW-1:0] dim_lim(input logic [DIM_W-1:0] v);
		logic [31:0] w;
		begin
			if (v == '0)
				w = 32'd1;
			else if (32'(v) > 32'(MAX_GRID))
				w = 32'(MAX_GRID);
			else
				w = 32'(v);
			return w[GW-1:0];
		end
	endfunction

	// configuration
	logic [SIZE_W-1:0] cell_size_q;
	logic [DIM_W-1:0]  grid_columns_q;
	logic [DIM_W-1:0]  grid_rows_q;
	logic [SIZE_W-1:0] size_eff;
	logic [GW-1:0]     cols_eff;
	logic [GW-1:0]     rows_eff;
	logic [GW-1:0]     cols_m1;
	logic [GW-1:0]     rows_m1;
	logic [LW-1:0]     limit_x_q;
	logic [LW-1:0]     limit_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q    <= CELL_SIZE_RST;
			grid_columns_q <= DIM_RST;
			grid_rows_q    <= DIM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CELL_SIZE:    cell_size_q    <= cfg_data[SIZE_W-1:0];
				REG_GRID_COLUMNS: grid_columns_q <= cfg_data[DIM_W-1:0];
				REG_GRID_ROWS:    grid_rows_q    <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		size_eff = (cell_size_q == '0) ? SIZE_W'(1) : cell_size_q;
		cols_eff = dim_lim(grid_columns_q);
		rows_eff = dim_lim(grid_rows_q);
		cols_m1  = cols_eff - GW'(1);
		rows_m1  = rows_eff - GW'(1);
	end

	// first coordinate past the grid on each axis
	always_ff @(posedge clk) begin
		limit_x_q <= LW'(cols_eff) * LW'(size_eff);
		limit_y_q <= LW'(rows_eff) * LW'(size_eff);
	end

	// handshake chain
	logic           v_s1;
	logic [NDS:0]   dv_vld_s;
	logic           rng_vld_s;
	logic           out_v_q;
	logic           rdy_s1;
	logic [NDS:0]   dv_rdy;
	logic           rng_rdy;
	logic           take;
	logic           adv;
	logic           at_end;
	logic           cap;

	always_comb begin
		take    = !out_v_q || (cell_ready && last_cell);
		adv     = out_v_q && cell_ready && !last_cell;
		rng_rdy = !rng_vld_s || take;
		dv_rdy[NDS] = !dv_vld_s[NDS] || rng_rdy;
		for (int k = NDS - 1; k >= 0; k--)
			dv_rdy[k] = !dv_vld_s[k] || dv_rdy[k+1];
		rdy_s1 = !v_s1 || dv_rdy[0];
	end

	assign box_ready = rdy_s1;

	// stage 1: corners, negative coordinates forced to zero
	logic [TAG_W-1:0]              tag_s1;
	logic [LANES-1:0][COORD_W-1:0] crd_s1;
	logic signed [COORD_W:0]       rx_w;
	logic signed [COORD_W:0]       by_w;
	logic [LANES-1:0][COORD_W-1:0] crd_w;

	always_comb begin
		rx_w = {box_left[COORD_W-1], box_left} + $signed({2'b00, box_width});
		by_w = {box_top[COORD_W-1], box_top} + $signed({2'b00, box_height});
		crd_w[LANE_X0] = box_left[COORD_W-1] ? '0 : box_left;
		crd_w[LANE_X1] = rx_w[COORD_W] ? '0 : rx_w[COORD_W-1:0];
		crd_w[LANE_Y0] = box_top[COORD_W-1] ? '0 : box_top;
		crd_w[LANE_Y1] = by_w[COORD_W] ? '0 : by_w[COORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (rdy_s1)
			v_s1 <= box_valid;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && box_valid) begin
			tag_s1 <= object_tag;
			crd_s1 <= crd_w;
		end
	end

	// stage 2: clamp flags, then the divider stages
	dv_t dv_s  [NDS+1];
	dv_t dv_in [NDS+1];

	always_comb begin
		dv_in[0].tag = tag_s1;
		dv_in[0].rem = crd_s1;
		dv_in[0].quo = '0;
		for (int l = 0; l < LANES; l++) begin
			if (l == LANE_X0 || l == LANE_X1)
				dv_in[0].hi[l] = CMW'(crd_s1[l]) >= CMW'(limit_x_q);
			else
				dv_in[0].hi[l] = CMW'(crd_s1[l]) >= CMW'(limit_y_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_vld_s[0] <= 1'b0;
		else if (dv_rdy[0])
			dv_vld_s[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (dv_rdy[0] && v_s1)
			dv_s[0] <= dv_in[0];
	end

	for (genvar k = 0; k < NDS; k++) begin : g_div
		// two restoring steps per stage; quotient is known to fit QW bits when not clamped
		always_comb begin
			dv_t           d;
			int            b;
			logic [RW-1:0] r_ext;
			logic [RW-1:0] t;
			d     = dv_s[k];
			r_ext = '0;
			t     = '0;
			for (int l = 0; l < LANES; l++) begin
				for (int s = 0; s < SPS; s++) begin
					b = QW - 1 - k * SPS - s;
					if (b >= 0) begin
						r_ext = RW'(d.rem[l]);
						t     = RW'(size_eff) << b;
						if (r_ext >= t) begin
							d.rem[l] = COORD_W'(r_ext - t);
							d.quo[l] = d.quo[l] | (QW'(1) << b);
						end
					end
				end
			end
			dv_in[k+1] = d;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_vld_s[k+1] <= 1'b0;
			else if (dv_rdy[k+1])
				dv_vld_s[k+1] <= dv_vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (dv_rdy[k+1] && dv_vld_s[k])
				dv_s[k+1] <= dv_in[k+1];
		end
	end

	// range stage: clamp to the border cells and form the first row index
	rng_t             rng_s;
	rng_t             rng_w;
	logic [PW-1:0]    row_prod;

	always_comb begin
		rng_w.tag = dv_s[NDS].tag;
		rng_w.x0  = dv_s[NDS].hi[LANE_X0] ? QW'(cols_m1) : dv_s[NDS].quo[LANE_X0];
		rng_w.x1  = dv_s[NDS].hi[LANE_X1] ? QW'(cols_m1) : dv_s[NDS].quo[LANE_X1];
		rng_w.y0  = dv_s[NDS].hi[LANE_Y0] ? QW'(rows_m1) : dv_s[NDS].quo[LANE_Y0];
		rng_w.y1  = dv_s[NDS].hi[LANE_Y1] ? QW'(rows_m1) : dv_s[NDS].quo[LANE_Y1];
		row_prod  = PW'(rng_w.y0) * PW'(cols_eff);
		rng_w.rowst = IDX_W'(row_prod) + IDX_W'(rng_w.x0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rng_vld_s <= 1'b0;
		else if (rng_rdy)
			rng_vld_s <= dv_vld_s[NDS];
	end

	always_ff @(posedge clk) begin
		if (rng_rdy && dv_vld_s[NDS])
			rng_s <= rng_w;
	end

	// output enumerator, also the output register
	logic [TAG_W-1:0] tag_q;
	logic [QW-1:0]    x_q;
	logic [QW-1:0]    x0_q;
	logic [QW-1:0]    x1_q;
	logic [QW-1:0]    y_q;
	logic [QW-1:0]    y1_q;
	logic [IDX_W-1:0] rowst_q;
	logic [IDX_W-1:0] idx_q;
	logic [NW-1:0]    n_q;
	logic [IDX_W-1:0] cols16;
	logic [IDX_W-1:0] next_row;

	always_comb begin
		cols16   = IDX_W'(cols_eff);
		next_row = rowst_q + cols16;
		at_end   = (x_q == x1_q) && (y_q == y1_q);
		cap      = (n_q == NW'(MAX_CELLS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (take)
			out_v_q <= rng_vld_s;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (rng_vld_s) begin
				tag_q   <= rng_s.tag;
				x_q     <= rng_s.x0;
				x0_q    <= rng_s.x0;
				x1_q    <= rng_s.x1;
				y_q     <= rng_s.y0;
				y1_q    <= rng_s.y1;
				rowst_q <= rng_s.rowst;
				idx_q   <= rng_s.rowst;
				n_q     <= '0;
			end
		end else if (adv) begin
			n_q <= n_q + NW'(1);
			if (x_q == x1_q) begin
				// wrap to the start of the next row
				x_q     <= x0_q;
				y_q     <= y_q + QW'(1);
				rowst_q <= next_row;
				idx_q   <= next_row;
			end else begin
				x_q   <= x_q + QW'(1);
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	assign cell_valid = out_v_q;
	assign tag_out    = tag_q;
	assign cell_index = idx_q;
	assign last_cell  = at_end || cap;
	assign truncated  = cap && !at_end;

endmodule

// ----- src/btgc_checker.sv -----
// port-level checks on the box-to-grid-cells unit, bound to its top level
// depends on btgc_pkg and assert_macros.svh

`include "assert_macros.svh"

module btgc_checker
	import btgc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             cell_valid,
	input logic             cell_ready,
	input logic [TAG_W-1:0] tag_out,
	input logic [IDX_W-1:0] cell_index,
	input logic             last_cell,
	input logic             truncated
);

	// a stalled result item holds
	`CHK_NEXT(a_out_hold, clk, arst_n, cell_valid && !cell_ready, cell_valid && $stable(cell_index) && $stable(tag_out) && $stable(last_cell), "result item changed while stalled")

	// truncation only shows on the closing item of a box
	`CHK_IMPL(a_trunc_last, clk, arst_n, cell_valid && truncated, last_cell, "truncated without last_cell")

	// a box's cells come without gaps and keep the tag
	`CHK_NEXT(a_box_cont, clk, arst_n, cell_valid && cell_ready && !last_cell, cell_valid && (tag_out == $past(tag_out)), "box cells interrupted or tag changed")

	// nothing offered while held in reset
	`CHK_IMPL(a_rst_quiet, clk, 1'b1, !arst_n, !cell_valid, "result valid during reset")

endmodule

bind box_to_grid_cells_unit btgc_checker u_btgc_checker (.*);

// ----- sim/tb.sv -----
// testbench for box_to_grid_cells_unit: boxes in, covered grid cells out, checked in order
// against a predictor of the clamped cell range; random gaps on both sides, one long output hold
// depends on btgc_pkg and box_to_grid_cells_unit

module tb
	import btgc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_AW-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [TAG_W-1:0]          tag;
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] top;
		logic [EXT_W-1:0]          width;
		logic [EXT_W-1:0]          height;
	} box_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [IDX_W-1:0] cell_idx;
		logic             last;
		logic             trunc;
	} cell_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_AW-1:0]         cfg_index;
	logic [CFG_W-1:0]          cfg_data;
	logic                      box_valid;
	logic                      box_ready;
	logic [TAG_W-1:0]          object_tag;
	logic signed [COORD_W-1:0] box_left;
	logic signed [COORD_W-1:0] box_top;
	logic [EXT_W-1:0]          box_width;
	logic [EXT_W-1:0]          box_height;
	logic                      cell_valid;
	logic                      cell_ready;
	logic [TAG_W-1:0]          tag_out;
	logic [IDX_W-1:0]          cell_index;
	logic                      last_cell;
	logic                      truncated;

	// register copies as the block should hold them
	logic [SIZE_W-1:0] cfg_cell_size = CELL_SIZE_RST;
	logic [DIM_W-1:0]  cfg_cols      = DIM_RST;
	logic [DIM_W-1:0]  cfg_rows      = DIM_RST;

	box_t        boxes_waiting[$];
	cell_t       cells_due[$];
	box_t        box_on_bus;
	int unsigned boxes_taken   = 0;
	int unsigned errors        = 0;
	int unsigned send_gap      = 0;
	int unsigned recv_gap      = 0;
	int unsigned hold_left     = 0;
	logic        pressure_done = 1'b0;
	logic        calm          = 1'b0;

	box_to_grid_cells_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.box_valid  (box_valid),
		.box_ready  (box_ready),
		.object_tag (object_tag),
		.box_left   (box_left),
		.box_top    (box_top),
		.box_width  (box_width),
		.box_height (box_height),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.tag_out    (tag_out),
		.cell_index (cell_index),
		.last_cell  (last_cell),
		.truncated  (truncated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(10, 4);
		return $urandom_range(40, 15);
	endfunction

	// zero means one, anything past the largest grid saturates
	function automatic int unsigned grid_span(input logic [DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_GRID_DEF)
			return MAX_GRID_DEF;
		return v;
	endfunction

	function automatic int unsigned cell_of(input int coord, input int unsigned size,
			input int unsigned count);
		int unsigned c;
		if (coord < 0)
			return 0;
		c = $unsigned(coord) / size;
		if (c >= count)
			c = count - 1;
		return c;
	endfunction

	// expected cells for one box, in scan order
	function automatic void bin_box(input box_t b);
		int unsigned sz, cols, rows, x0, x1, y0, y1, total, emit, n;
		int          lx, ty;
		cell_t       c;
		sz = (cfg_cell_size == 0) ? 1 : cfg_cell_size;
		cols = grid_span(cfg_cols);
		rows = grid_span(cfg_rows);
		lx = $signed(b.left);
		ty = $signed(b.top);
		x0 = cell_of(lx, sz, cols);
		x1 = cell_of(lx + int'(b.width), sz, cols);
		y0 = cell_of(ty, sz, rows);
		y1 = cell_of(ty + int'(b.height), sz, rows);
		total = (x1 - x0 + 1) * (y1 - y0 + 1);
		emit = (total > MAX_CELLS_DEF) ? MAX_CELLS_DEF : total;
		n = 0;
		for (int unsigned y = y0; y <= y1 && n < emit; y++) begin
			for (int unsigned x = x0; x <= x1 && n < emit; x++) begin
				n++;
				c.tag = b.tag;
				c.cell_idx = IDX_W'(y * cols + x);
				c.last = (n == emit);
				c.trunc = (n == emit) && (total > MAX_CELLS_DEF);
				cells_due = {cells_due, c};
			end
		end
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
		if (v < -32768)
			return 16'sh8000;
		if (v > 32767)
			return 16'sh7FFF;
		return COORD_W'(v);
	endfunction

	function automatic logic signed [COORD_W-1:0] edge_coord();
		case ($urandom_range(3))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			default: return 16'shFFFF;
		endcase
	endfunction

	function automatic box_t random_box();
		box_t        b;
		int unsigned r, sz, reach_x, reach_y, cw, ch;
		int          wd, ht;
		sz = (cfg_cell_size == 0) ? 1 : cfg_cell_size;
		reach_x = (grid_span(cfg_cols) + 2) * sz;
		reach_y = (grid_span(cfg_rows) + 2) * sz;
		if (reach_x > 65535)
			reach_x = 65535;
		if (reach_y > 65535)
			reach_y = 65535;
		b.tag = TAG_W'($urandom);
		r = $urandom_range(99);
		if (r < 70) begin
			// box on or near the map, mostly a few cells across, now and then past the cap
			cw = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(2);
			ch = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(2);
			b.left = clamp_coord(int'($urandom_range(reach_x)) - int'(sz));
			b.top = clamp_coord(int'($urandom_range(reach_y)) - int'(sz));
			wd = int'($urandom_range(cw * sz + sz - 1));
			ht = int'($urandom_range(ch * sz + sz - 1));
			b.width = (wd > 32767) ? 15'h7FFF : EXT_W'(wd);
			b.height = (ht > 32767) ? 15'h7FFF : EXT_W'(ht);
		end else if (r < 90) begin
			b.left = COORD_W'($urandom);
			b.top = COORD_W'($urandom);
			b.width = EXT_W'($urandom);
			b.height = EXT_W'($urandom);
		end else begin
			b.left = edge_coord();
			b.top = edge_coord();
			b.width = $urandom_range(1) ? 15'h7FFF : 15'h0000;
			b.height = $urandom_range(1) ? 15'h7FFF : 15'h0000;
		end
		return b;
	endfunction

	task automatic queue_box(input logic [TAG_W-1:0] tag, input int lx, input int ty,
			input int wd, input int ht);
		box_t b;
		b.tag = tag;
		b.left = COORD_W'(lx);
		b.top = COORD_W'(ty);
		b.width = EXT_W'(wd);
		b.height = EXT_W'(ht);
		boxes_waiting = {boxes_waiting, b};
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CELL_SIZE: cfg_cell_size = data[SIZE_W-1:0];
			REG_GRID_COLUMNS: cfg_cols = data[DIM_W-1:0];
			REG_GRID_ROWS: cfg_rows = data[DIM_W-1:0];
			default: ;
		endcase
	endtask

	// let register writes land, then hand items over away from the clock edge
	task automatic begin_phase();
		repeat (2) @(posedge clk);
		@(negedge clk);
	endtask

	// wait until every box is in and every cell is out, then let the pipeline drain
	task automatic settle();
		int unsigned waited;
		waited = 0;
		while (boxes_waiting.size() != 0 || box_valid)
			@(negedge clk);
		while (cells_due.size() != 0 && waited < 100000) begin
			@(negedge clk);
			waited++;
		end
		if (cells_due.size() != 0) begin
			$error("%0d expected cell items never arrived", cells_due.size());
			errors++;
			cells_due.delete();
		end
		repeat (16) @(posedge clk);
		@(negedge clk);
	endtask

	// sender
	always @(posedge clk) begin
		logic offer;
		offer = box_valid;
		if (arst_n) begin
			if (box_valid && box_ready) begin
				bin_box(box_on_bus);
				boxes_taken++;
				offer = 1'b0;
				send_gap = pick_gap();
			end
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (boxes_waiting.size() != 0) begin
					box_on_bus = boxes_waiting.pop_front();
					object_tag <= box_on_bus.tag;
					box_left <= box_on_bus.left;
					box_top <= box_on_bus.top;
					box_width <= box_on_bus.width;
					box_height <= box_on_bus.height;
					offer = 1'b1;
				end
			end
		end
		box_valid <= offer;
	end

	// receiver and checker
	always @(posedge clk) begin
		cell_t want;
		logic  take;
		take = cell_ready;
		if (arst_n) begin
			if (cell_valid && cell_ready) begin
				if (cells_due.size() == 0) begin
					$error("unexpected cell item: tag %h index %0d", tag_out, cell_index);
					errors++;
				end else begin
					want = cells_due.pop_front();
					if (tag_out !== want.tag) begin
						$error("tag_out: expected %h, actual %h", want.tag, tag_out);
						errors++;
					end
					if (cell_index !== want.cell_idx) begin
						$error("cell_index: expected %0d, actual %0d", want.cell_idx,
							cell_index);
						errors++;
					end
					if (last_cell !== want.last) begin
						$error("last_cell: expected %b, actual %b", want.last, last_cell);
						errors++;
					end
					if (truncated !== want.trunc) begin
						$error("truncated: expected %b, actual %b", want.trunc, truncated);
						errors++;
					end
				end
				recv_gap = pick_gap();
			end
			// one long hold while boxes keep coming, so the block backs up to its input
			if (!pressure_done && boxes_taken >= 60) begin
				hold_left = 400;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				take = 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				take = 1'b0;
			end else begin
				take = 1'b1;
			end
		end
		cell_ready <= take;
	end

	initial begin
		int unsigned      r;
		logic [CFG_W-1:0] d;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CELL_SIZE;
		cfg_data = '0;
		box_valid = 1'b0;
		object_tag = '0;
		box_left = '0;
		box_top = '0;
		box_width = '0;
		box_height = '0;
		cell_ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		begin_phase();

		// reset values: 32 by 32 grid of 32-unit cells
		queue_box(16'h0000, 0, 0, 0, 0);
		queue_box(16'hFFFF, -32768, -32768, 0, 0);
		queue_box(16'h1234, 32767, 32767, 32767, 32767);
		queue_box(16'h00A5, -32768, -32768, 32767, 32767);
		queue_box(16'h0101, 0, 0, 255, 255);
		queue_box(16'h0102, 0, 0, 256, 255);
		queue_box(16'h0103, 40, 100, 300, 0);
		queue_box(16'h0104, 1000, -50, 0, 2000);
		queue_box(16'h0105, 1023, 1023, 1, 1);
		queue_box(16'h0106, -1, -1, 1, 1);
		settle();

		// zero size and zero dimensions act as one
		write_reg(REG_CELL_SIZE, '0);
		write_reg(REG_GRID_COLUMNS, '0);
		write_reg(REG_GRID_ROWS, '0);
		begin_phase();
		queue_box(16'h0201, 7, 9, 32767, 0);
		queue_box(16'h0202, -32768, 32767, 32767, 32767);
		settle();

		// largest cell, oversized columns saturate, out-of-range index ignored
		write_reg(REG_CELL_SIZE, 13'h1FFF);
		write_reg(REG_GRID_COLUMNS, 13'h01FF);
		write_reg(REG_GRID_ROWS, 13'd256);
		write_reg(REG_SPARE, 13'h1FFF);
		begin_phase();
		queue_box(16'h0301, 32767, 32767, 0, 0);
		queue_box(16'h0302, 0, 0, 32767, 32767);
		queue_box(16'h0303, 8190, 8190, 1, 1);
		settle();

		// unit cells on the full grid, far corner gives the widest index
		write_reg(REG_CELL_SIZE, 13'd1);
		write_reg(REG_GRID_COLUMNS, 13'd256);
		write_reg(REG_GRID_ROWS, 13'd256);
		begin_phase();
		queue_box(16'h0401, 255, 255, 0, 0);
		queue_box(16'h0402, 256, 300, 5, 5);
		queue_box(16'h0403, 250, 250, 10, 10);
		queue_box(16'h0404, 3, 0, 2, 7);
		settle();

		// one column, one row grids
		write_reg(REG_GRID_COLUMNS, 13'd1);
		write_reg(REG_GRID_ROWS, 13'd1);
		begin_phase();
		queue_box(16'h0501, 0, 0, 32767, 32767);
		queue_box(16'h0502, -5, 12, 0, 3);
		settle();

		for (int p = 0; p < 6; p++) begin
			calm = (p == 2);
			r = $urandom_range(99);
			if (r < 55)
				d = CFG_W'($urandom_range(64, 1));
			else if (r < 80)
				d = CFG_W'($urandom);
			else if (r < 90)
				d = '0;
			else
				d = '1;
			write_reg(REG_CELL_SIZE, d);
			d = CFG_W'($urandom);
			if ($urandom_range(3) != 0)
				d[DIM_W-1:0] = DIM_W'($urandom_range(40, 1));
			write_reg(REG_GRID_COLUMNS, d);
			d = CFG_W'($urandom);
			if ($urandom_range(3) != 0)
				d[DIM_W-1:0] = DIM_W'($urandom_range(40, 1));
			write_reg(REG_GRID_ROWS, d);
			if ($urandom_range(1))
				write_reg(REG_SPARE, CFG_W'($urandom));
			begin_phase();
			repeat (47)
				boxes_waiting = {boxes_waiting, random_box()};
			settle();
		end

		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule

// ----- box_to_grid_cells_unit.f -----
+incdir+src
src/btgc_pkg.sv
src/box_to_grid_cells_unit.sv
src/btgc_checker.sv
sim/tb.sv
